### rtl/core/assert_macros.svh
// Assertion macros for the contour bounding box and moment accumulator.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CBMA_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("cbma assertion failed");
`define CBMA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cbma assertion failed");
`else
`define CBMA_ASSERT(label, clk, rstn, prop)
`define CBMA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### rtl/core/cbma_pkg.sv
// Shared types, widths, caps and saturating-add helpers for the
// contour bounding box and moment accumulator. No dependencies.
`default_nettype none
package cbma_pkg;

    localparam int COORD_BITS = 12;
    localparam int EXT_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * COORD_BITS;
    localparam int COUNT_BITS = 21;
    localparam int LIN_BITS   = 32;
    localparam int SQ_BITS    = 44;

    localparam logic [COUNT_BITS-1:0] MAX_POINTS = COUNT_BITS'(1048576);

    localparam logic [LIN_BITS-1:0] CAP_LIN =
        LIN_BITS'(((64'd1 << COORD_BITS) - 64'd1) * 64'd1048576);
    localparam logic [SQ_BITS-1:0] CAP_SQ =
        SQ_BITS'(((64'd1 << COORD_BITS) - 64'd1) * ((64'd1 << COORD_BITS) - 64'd1)
                 * 64'd1048576);

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [EXT_BITS-1:0]   ext_t;
    typedef logic [PROD_BITS-1:0]  prod_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [LIN_BITS-1:0]   lin_t;
    typedef logic [SQ_BITS-1:0]    sq_t;

    // One axis of the box: low edge and extent
    typedef struct packed {
        coord_t lo;
        ext_t   ext;
    } axis_t;

    function automatic lin_t sat_lin(input lin_t acc, input coord_t v);
        logic [LIN_BITS:0] s;
        s = {1'b0, acc} + (LIN_BITS + 1)'(v);
        sat_lin = (s > {1'b0, CAP_LIN}) ? CAP_LIN : s[LIN_BITS-1:0];
    endfunction

    function automatic sq_t sat_sq(input sq_t acc, input prod_t v);
        logic [SQ_BITS:0] s;
        s = {1'b0, acc} + (SQ_BITS + 1)'(v);
        sat_sq = (s > {1'b0, CAP_SQ}) ? CAP_SQ : s[SQ_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/core/contour_bbox_moment_accumulator.sv
// Contour bounding box and raw moment accumulator, top level.
// Depends on cbma_pkg, cbma_axis_grow and assert_macros.svh.
//
// Channel | Dir | tdata                         | tuser     | Per transfer
// s_      | in  | px, py                        | start_new | one contour point
// m_      | out | box, point_total, five sums   | -         | one result per point
//
// One point per cycle is sustained while no result is stalled.
// The squares and the cross product are computed into the input register, the box update and
// the saturating sums between that register and the state, which is the result register.
// A stalled result holds the state, so the input register fills and then s_tready drops.
// Synchronous active-low reset clears all state; the first point after reset starts a contour.
`default_nettype none
`include "assert_macros.svh"
module contour_bbox_moment_accumulator (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,   // px[11:0], py[23:12]
    input  wire logic         s_tuser,   // start_new
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // box_left[11:0], box_top[23:12], box_width[36:24], box_height[49:37],
    // point_total[70:50], sum_x[102:71], sum_y[134:103], sum_xy[178:135],
    // sum_xx[222:179], sum_yy[266:223], zero[271:267]
    output logic [271:0]      m_tdata
);

    localparam int CB = cbma_pkg::COORD_BITS;

    // input stage
    logic             in_valid_reg;
    logic             fresh_reg;
    cbma_pkg::coord_t x_reg, y_reg;
    cbma_pkg::prod_t  xy_reg, xx_reg, yy_reg;

    // contour state, also the result register
    logic             out_valid_reg;
    cbma_pkg::axis_t  hor_reg, ver_reg;
    cbma_pkg::axis_t  hor_next, ver_next;
    cbma_pkg::count_t count_reg, count_next;
    cbma_pkg::lin_t   acc_x_reg, acc_y_reg, acc_x_next, acc_y_next;
    cbma_pkg::sq_t    acc_xy_reg, acc_xx_reg, acc_yy_reg;
    cbma_pkg::sq_t    acc_xy_next, acc_xx_next, acc_yy_next;

    cbma_pkg::coord_t px_in, py_in;
    logic             advance, s_take, fresh;

    assign px_in = s_tdata[CB-1:0];
    assign py_in = s_tdata[2*CB-1:CB];

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = aresetn && (!in_valid_reg || advance);
    assign s_take   = s_tvalid && s_tready;
    assign fresh    = fresh_reg || (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_take) begin
            fresh_reg <= s_tuser;
            x_reg     <= px_in;
            y_reg     <= py_in;
            xy_reg    <= cbma_pkg::prod_t'(px_in) * cbma_pkg::prod_t'(py_in);
            xx_reg    <= cbma_pkg::prod_t'(px_in) * cbma_pkg::prod_t'(px_in);
            yy_reg    <= cbma_pkg::prod_t'(py_in) * cbma_pkg::prod_t'(py_in);
        end
    end

    cbma_axis_grow u_hor (
        .cur   (hor_reg),
        .p     (x_reg),
        .fresh (fresh),
        .nxt   (hor_next)
    );

    cbma_axis_grow u_ver (
        .cur   (ver_reg),
        .p     (y_reg),
        .fresh (fresh),
        .nxt   (ver_next)
    );

    always_comb begin
        if (fresh) begin
            count_next  = cbma_pkg::count_t'(1);
            acc_x_next  = cbma_pkg::lin_t'(x_reg);
            acc_y_next  = cbma_pkg::lin_t'(y_reg);
            acc_xy_next = cbma_pkg::sq_t'(xy_reg);
            acc_xx_next = cbma_pkg::sq_t'(xx_reg);
            acc_yy_next = cbma_pkg::sq_t'(yy_reg);
        end else begin
            // hold the count at its ceiling
            count_next  = (count_reg < cbma_pkg::MAX_POINTS) ?
                          count_reg + cbma_pkg::count_t'(1) : count_reg;
            acc_x_next  = cbma_pkg::sat_lin(acc_x_reg, x_reg);
            acc_y_next  = cbma_pkg::sat_lin(acc_y_reg, y_reg);
            acc_xy_next = cbma_pkg::sat_sq(acc_xy_reg, xy_reg);
            acc_xx_next = cbma_pkg::sat_sq(acc_xx_reg, xx_reg);
            acc_yy_next = cbma_pkg::sat_sq(acc_yy_reg, yy_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            hor_reg       <= '0;
            ver_reg       <= '0;
            count_reg     <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            acc_xy_reg    <= '0;
            acc_xx_reg    <= '0;
            acc_yy_reg    <= '0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                hor_reg       <= hor_next;
                ver_reg       <= ver_next;
                count_reg     <= count_next;
                acc_x_reg     <= acc_x_next;
                acc_y_reg     <= acc_y_next;
                acc_xy_reg    <= acc_xy_next;
                acc_xx_reg    <= acc_xx_next;
                acc_yy_reg    <= acc_yy_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, acc_yy_reg, acc_xx_reg, acc_xy_reg, acc_y_reg, acc_x_reg,
                       count_reg, ver_reg.ext, hor_reg.ext, ver_reg.lo, hor_reg.lo};

    `CBMA_ASSERT(a_count_range, aclk, aresetn, !out_valid_reg || ((count_reg != '0) && (count_reg <= cbma_pkg::MAX_POINTS)))
    `CBMA_ASSERT_NEXT(a_fresh_count, aclk, aresetn, advance && fresh, count_reg == cbma_pkg::count_t'(1))
    `CBMA_ASSERT(a_box_fits, aclk, aresetn, !out_valid_reg || (({1'b0, hor_reg.lo} + hor_reg.ext <= 14'd4096) && ({1'b0, ver_reg.lo} + ver_reg.ext <= 14'd4096)))
    `CBMA_ASSERT(a_sum_caps, aclk, aresetn, (acc_xy_reg <= cbma_pkg::CAP_SQ) && (acc_x_reg <= cbma_pkg::CAP_LIN))

endmodule
`default_nettype wire

### rtl/core/cbma_axis_grow.sv
// Grows one axis of the bounding box to cover a new coordinate.
// Depends on cbma_pkg for the axis type and coordinate widths.
`default_nettype none
module cbma_axis_grow (
    input  wire cbma_pkg::axis_t  cur,
    input  wire cbma_pkg::coord_t p,
    input  wire logic             fresh,
    output cbma_pkg::axis_t       nxt
);

    cbma_pkg::ext_t              ext1;
    logic [cbma_pkg::EXT_BITS:0] hi;

    // an empty extent counts as one pixel
    assign ext1 = (cur.ext == '0) ? cbma_pkg::ext_t'(1) : cur.ext;
    assign hi   = {2'b00, cur.lo} + {1'b0, ext1} - (cbma_pkg::EXT_BITS + 1)'(1);

    always_comb begin
        nxt.lo  = cur.lo;
        nxt.ext = ext1;
        if (fresh) begin
            nxt.lo  = p;
            nxt.ext = cbma_pkg::ext_t'(1);
        end else if (p < cur.lo) begin
            nxt.lo  = p;
            nxt.ext = ext1 + {1'b0, cur.lo - p};
        end else if ({2'b00, p} > hi) begin
            nxt.ext = {1'b0, p - cur.lo} + cbma_pkg::ext_t'(1);
        end
    end

endmodule
`default_nettype wire
